FILE: hdl/dmc_pkg.sv
package dmc_pkg;

  localparam int RESP_MAX    = 64;
  localparam int HORIZON_MAX = 16;
  localparam int GAIN_MAX    = RESP_MAX + HORIZON_MAX;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 7;
  localparam int RESP_LEN_W = 7;
  localparam int HORIZON_W = 5;

  localparam int RESP_AW = $clog2(RESP_MAX);
  localparam int GAIN_AW = $clog2(GAIN_MAX);
  localparam int N_W     = $clog2(RESP_MAX + 1);
  localparam int T_W     = $clog2(HORIZON_MAX + 1);
  localparam int CNT_W   = $clog2(GAIN_MAX + 1);

  localparam int PROD_W  = 2 * DATA_W;
  localparam int QPROD_W = PROD_W - 16;
  localparam int ACC_W   = QPROD_W + $clog2(GAIN_MAX) + 1;
  localparam int BASE_W  = DATA_W + 4;

  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_RESP_LEN     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_HORIZON = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP_ENABLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP_MIN    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP_MAX    = 3'd4;

  localparam logic [RESP_LEN_W-1:0] RESP_LEN_RST     = 7'd64;
  localparam logic [HORIZON_W-1:0]  CTRL_HORIZON_RST = 5'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP      = 2'd0,
    CMD_LOAD_RESP = 2'd1,
    CMD_LOAD_GAIN = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_e;

  typedef logic signed [DATA_W-1:0] word_t;

  function automatic word_t sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

FILE: hdl/dmc_if.sv
interface dmc_in_if import dmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  entry_index;
  logic signed [DATA_W-1:0] entry_value;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;

  modport source (output valid, command, entry_index, entry_value, setpoint, measured,
                  input ready);
  modport sink (input valid, command, entry_index, entry_value, setpoint, measured,
                output ready);
endinterface

interface dmc_out_if import dmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] drive;
  logic signed [DATA_W-1:0] increment;
  logic              clamped;

  modport source (output valid, drive, increment, clamped, input ready);
  modport sink (input valid, drive, increment, clamped, output ready);
endinterface

FILE: hdl/dmc_siso_controller_step_core.sv
// Channel   Dir   Payload                                           Accept
// req_i     in    command, entry_index, entry_value, setpoint,      valid & ready
//                 measured
// rsp_o     out   drive, increment, clamped                         valid & ready
// apb       in    resp_len, ctrl_horizon, clamp_enable, clamp_min,  psel & penable & pwrite
//                 clamp_max at byte address 4*i
//
// Load and clear words complete in the idle state. A control step makes one pass of n
// (resp_len limited to 2..64) over the free-response memory and one pass of m = n + t
// (t = ctrl_horizon limited to 1..16) over the gain memory, both through the single
// multiply-accumulate unit. The first step after reset or clear skips both passes.
// Reset clears the state at once; the free-response memory reads as zero through
// per-entry valid bits. A stalled result holds in the output register; the next
// step waits for it only in its final state.
module dmc_siso_controller_step_core import dmc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  dmc_in_if.sink             req_i,
  dmc_out_if.source          rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SHIFT, ST_SDRAIN, ST_BASE, ST_ERR, ST_EDRAIN, ST_SUM, ST_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic [RESP_LEN_W-1:0] resp_len_q;
  logic [HORIZON_W-1:0]  ctrl_horizon_q;
  logic                  clamp_en_q;
  word_t                 clamp_min_q;
  word_t                 clamp_max_q;
  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  cfg_idx;

  // control state
  logic [CNT_W-1:0] cnt_q;
  logic             mode_q;
  logic             primed_q;
  logic             first_q;
  word_t            held_q;
  word_t            li_q;
  word_t            setpoint_q;
  word_t            measured_q;
  word_t            next_q;
  logic             rsp_valid_q;
  word_t            drive_q;
  word_t            inc_q;
  logic             clamped_q;

  logic [RESP_MAX-1:0] fr_vld_q;

  // memories
  word_t fr_mem [RESP_MAX];
  word_t sr_mem [RESP_MAX];
  word_t g_mem  [GAIN_MAX];

  // pipeline
  logic               b_v_q, c_v_q, d_v_q;
  logic [RESP_AW-1:0] b_idx_q, c_idx_q, d_idx_q;
  logic               frv_q;
  word_t              fr_rd_q, sr_rd_q, g_rd_q;
  word_t              op_a_q, op_b_q, add_q, add_d_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [BASE_W-1:0]  base_q;
  word_t                     fr0_q;

  logic               req_fire, rsp_fire, issue;
  cmd_e               req_cmd;
  logic [N_W-1:0]     n_c;
  logic [T_W-1:0]     t_c;
  logic [CNT_W-1:0]   m_c, nxt_c, k_c;
  logic [RESP_AW-1:0] fr_raddr;
  word_t              fr_val_c, err_c, fr_new_c, clamp_c, inc_c;
  logic signed [PROD_W-1:0]  rnd_full_c;
  logic signed [QPROD_W-1:0] rnd_c;
  logic               fr_we, lim_c, pipe_busy;

  assign req_cmd   = cmd_e'(req_i.command);
  assign req_fire  = req_i.valid && req_i.ready;
  assign rsp_fire  = rsp_o.valid && rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.drive     = drive_q;
  assign rsp_o.increment = inc_q;
  assign rsp_o.clamped   = clamped_q;
  assign pipe_busy = b_v_q || c_v_q || d_v_q;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_len_q     <= RESP_LEN_RST;
      ctrl_horizon_q <= CTRL_HORIZON_RST;
      clamp_en_q     <= 1'b0;
      clamp_min_q    <= '0;
      clamp_max_q    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RESP_LEN:     resp_len_q     <= pwdata[RESP_LEN_W-1:0];
        REG_CTRL_HORIZON: ctrl_horizon_q <= pwdata[HORIZON_W-1:0];
        REG_CLAMP_ENABLE: clamp_en_q     <= pwdata[0];
        REG_CLAMP_MIN:    clamp_min_q    <= pwdata;
        REG_CLAMP_MAX:    clamp_max_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RESP_LEN:     prdata = 32'(resp_len_q);
      REG_CTRL_HORIZON: prdata = 32'(ctrl_horizon_q);
      REG_CLAMP_ENABLE: prdata = 32'(clamp_en_q);
      REG_CLAMP_MIN:    prdata = clamp_min_q;
      REG_CLAMP_MAX:    prdata = clamp_max_q;
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- lengths
  always_comb begin
    if (resp_len_q < RESP_LEN_W'(2)) begin
      n_c = N_W'(2);
    end else if (32'(resp_len_q) > RESP_MAX) begin
      n_c = N_W'(RESP_MAX);
    end else begin
      n_c = N_W'(resp_len_q);
    end
    if (ctrl_horizon_q == '0) begin
      t_c = T_W'(1);
    end else if (32'(ctrl_horizon_q) > HORIZON_MAX) begin
      t_c = T_W'(HORIZON_MAX);
    end else begin
      t_c = T_W'(ctrl_horizon_q);
    end
  end

  assign m_c   = CNT_W'(n_c) + CNT_W'(t_c);
  // both passes read the free response at min(i + 1, n - 1)
  assign nxt_c = cnt_q + CNT_W'(1);
  assign k_c   = (nxt_c < CNT_W'(n_c)) ? nxt_c : CNT_W'(n_c) - CNT_W'(1);
  assign fr_raddr = k_c[RESP_AW-1:0];
  assign issue = (state_q == ST_SHIFT) || (state_q == ST_ERR);

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      fr_mem[d_idx_q] <= fr_new_c;
    end
    fr_rd_q <= fr_mem[fr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && req_cmd == CMD_LOAD_RESP && 32'(req_i.entry_index) < RESP_MAX) begin
      sr_mem[RESP_AW'(req_i.entry_index)] <= req_i.entry_value;
    end
    sr_rd_q <= sr_mem[cnt_q[RESP_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && req_cmd == CMD_LOAD_GAIN && 32'(req_i.entry_index) < GAIN_MAX) begin
      g_mem[GAIN_AW'(req_i.entry_index)] <= req_i.entry_value;
    end
    g_rd_q <= g_mem[cnt_q[GAIN_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= '0;
    end else if (req_fire && req_cmd == CMD_CLEAR) begin
      fr_vld_q <= '0;
    end else if (fr_we) begin
      fr_vld_q[d_idx_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- datapath
  assign fr_val_c   = frv_q ? fr_rd_q : '0;
  assign err_c      = sat32(64'(base_q) - 64'(fr_val_c));
  assign rnd_full_c = prod_q + 64'sd32768;
  assign rnd_c      = rnd_full_c[PROD_W-1:16];
  assign fr_new_c   = sat32(64'(add_d_q) + 64'(rnd_c));
  assign fr_we      = d_v_q && !mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      b_v_q <= issue;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_idx_q <= cnt_q[RESP_AW-1:0];
    frv_q   <= fr_vld_q[fr_raddr];
    c_idx_q <= b_idx_q;
    if (mode_q) begin
      op_a_q <= g_rd_q;
      op_b_q <= err_c;
    end else begin
      op_a_q <= sr_rd_q;
      op_b_q <= li_q;
    end
    add_q   <= fr_val_c;
    d_idx_q <= c_idx_q;
    add_d_q <= add_q;
    prod_q  <= op_a_q * op_b_q;
    if (fr_we && d_idx_q == '0) begin
      fr0_q <= fr_new_c;
    end
    if (state_q == ST_BASE) begin
      base_q <= BASE_W'(setpoint_q) - BASE_W'(measured_q) + BASE_W'(fr0_q);
      acc_q  <= '0;
    end else if (d_v_q && mode_q) begin
      acc_q <= acc_q + ACC_W'(rnd_c);
    end
  end

  // ---------------------------------------------------------------- limit
  always_comb begin
    clamp_c = next_q;
    lim_c   = 1'b0;
    if (clamp_en_q) begin
      if (next_q > clamp_max_q) begin
        clamp_c = clamp_max_q;
        lim_c   = 1'b1;
      end
      if (clamp_min_q > clamp_c) begin
        clamp_c = clamp_min_q;
        lim_c   = 1'b1;
      end
    end
  end

  assign inc_c = sat32(64'(clamp_c) - 64'(held_q));

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      primed_q    <= 1'b0;
      first_q     <= 1'b0;
      held_q      <= '0;
      li_q        <= '0;
      setpoint_q  <= '0;
      measured_q  <= '0;
      next_q      <= '0;
      rsp_valid_q <= 1'b0;
      drive_q     <= '0;
      inc_q       <= '0;
      clamped_q   <= 1'b0;
    end else begin
      // the final state decides the output valid on its own
      if (rsp_fire && state_q != ST_FIN) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            unique case (req_cmd) inside
              CMD_STEP: begin
                setpoint_q <= req_i.setpoint;
                measured_q <= req_i.measured;
                cnt_q      <= '0;
                mode_q     <= 1'b0;
                first_q    <= !primed_q;
                state_q    <= primed_q ? ST_SHIFT : ST_FIN;
              end
              CMD_LOAD_RESP, CMD_LOAD_GAIN: ;
              CMD_CLEAR: begin
                li_q     <= '0;
                held_q   <= '0;
                primed_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_SHIFT: begin
          cnt_q <= nxt_c;
          if (cnt_q == CNT_W'(n_c) - CNT_W'(1)) begin
            state_q <= ST_SDRAIN;
          end
        end
        ST_SDRAIN: begin
          // wait until every shifted word is written back
          if (!pipe_busy) begin
            state_q <= ST_BASE;
          end
        end
        ST_BASE: begin
          cnt_q   <= '0;
          mode_q  <= 1'b1;
          state_q <= ST_ERR;
        end
        ST_ERR: begin
          cnt_q <= nxt_c;
          if (cnt_q == m_c - CNT_W'(1)) begin
            state_q <= ST_EDRAIN;
          end
        end
        ST_EDRAIN: begin
          if (!pipe_busy) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          next_q  <= sat32(64'(held_q) + 64'(acc_q));
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            if (first_q) begin
              drive_q   <= held_q;
              inc_q     <= '0;
              clamped_q <= 1'b0;
              primed_q  <= 1'b1;
            end else begin
              drive_q   <= clamp_c;
              inc_q     <= inc_c;
              clamped_q <= lim_c;
              held_q    <= clamp_c;
              li_q      <= inc_c;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && d_v_q && !mode_q) |-> (d_idx_q < fr_raddr))
    else $error("free-response write overtakes pending read");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BASE || state_q == ST_SUM) |-> !pipe_busy)
    else $error("pass ended with words in flight");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !pipe_busy)
    else $error("word accepted while pipeline busy");

  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside final state");

  a_fin_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && rsp_o.valid && !rsp_o.ready) |=> (state_q == ST_FIN && $stable(held_q)))
    else $error("step finished over a pending result");

endmodule

FILE: tb/testbench.sv
module testbench;
  import dmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    SETTLE_CYCLES  = 200;
  localparam int    LONG_HOLD      = 2500;
  localparam int    WATCHDOG_LIMIT = 20000;
  localparam word_t W_MAX          = 32'sh7fffffff;
  localparam word_t W_MIN          = 32'sh80000000;
  localparam int    ONE            = 65536;

  typedef struct {
    cmd_e             command;
    logic [IDX_W-1:0] entry_index;
    word_t            entry_value;
    word_t            setpoint;
    word_t            measured;
  } ctl_word_t;

  typedef struct {
    word_t drive;
    word_t increment;
    logic  clamped;
  } ctl_out_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  dmc_in_if  req_if ();
  dmc_out_if rsp_if ();

  dmc_siso_controller_step_core u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // controller state mirror
  logic [RESP_LEN_W-1:0] resp_len_q;
  logic [HORIZON_W-1:0]  horizon_q;
  logic                  clamp_en_q;
  word_t                 clamp_lo_q;
  word_t                 clamp_hi_q;
  word_t                 resp_tab [RESP_MAX];
  word_t                 gain_tab [GAIN_MAX];
  longint                free_resp [RESP_MAX];
  longint                last_inc;
  longint                held_out;
  bit                    primed;

  ctl_word_t cmd_words_q [$];
  ctl_out_t  predicted_moves [$];
  ctl_word_t on_bus;
  ctl_out_t  want;

  int words_posted  = 0;
  int words_taken   = 0;
  int fail_count    = 0;
  int hold_requests = 0;
  int hold_taken    = 0;
  int in_gap        = 0;
  int out_stall     = 0;
  int quiet_cycles  = 0;
  bit in_idle_on    = 1'b1;
  bit out_idle_on   = 1'b1;

  function automatic longint clip32(longint v);
    if (v > longint'(W_MAX)) return longint'(W_MAX);
    if (v < longint'(W_MIN)) return longint'(W_MIN);
    return v;
  endfunction

  // Q16.16 product, round half up
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic void wipe_loop_state();
    foreach (free_resp[i]) free_resp[i] = 0;
    last_inc = 0;
    held_out = 0;
    primed   = 1'b0;
  endfunction

  function automatic void advance_controller(ctl_word_t w);
    int       n;
    int       t;
    int       k;
    longint   src;
    longint   disturb;
    longint   acc;
    longint   err;
    longint   next_out;
    ctl_out_t o;
    case (w.command)
      CMD_LOAD_RESP: begin
        if (w.entry_index < RESP_MAX) resp_tab[w.entry_index] = w.entry_value;
      end
      CMD_LOAD_GAIN: begin
        if (w.entry_index < GAIN_MAX) gain_tab[w.entry_index] = w.entry_value;
      end
      CMD_CLEAR: begin
        wipe_loop_state();
      end
      default: begin
        if (!primed) begin
          primed      = 1'b1;
          o.drive     = word_t'(held_out);
          o.increment = '0;
          o.clamped   = 1'b0;
        end else begin
          n = (resp_len_q < 2) ? 2 : (resp_len_q > RESP_MAX) ? RESP_MAX : int'(resp_len_q);
          t = (horizon_q < 1) ? 1 : (horizon_q > HORIZON_MAX) ? HORIZON_MAX : int'(horizon_q);
          // shift the free response, last element held, and add the last move
          for (int i = 0; i < n; i++) begin
            src = (i + 1 < n) ? free_resp[i + 1] : free_resp[n - 1];
            free_resp[i] = clip32(src + qmul(longint'(resp_tab[i]), last_inc));
          end
          disturb = longint'(w.measured) - free_resp[0];
          acc  = 0;
          for (int i = 0; i < n + t; i++) begin
            k   = (i + 1 < n) ? i + 1 : n - 1;
            err = clip32(longint'(w.setpoint) - free_resp[k] - disturb);
            acc += qmul(longint'(gain_tab[i]), err);
          end
          next_out  = clip32(held_out + acc);
          o.clamped = 1'b0;
          if (clamp_en_q) begin
            // max first, so min wins when the limits cross
            if (next_out > longint'(clamp_hi_q)) begin
              next_out  = longint'(clamp_hi_q);
              o.clamped = 1'b1;
            end
            if (longint'(clamp_lo_q) > next_out) begin
              next_out  = longint'(clamp_lo_q);
              o.clamped = 1'b1;
            end
          end
          last_inc    = clip32(next_out - held_out);
          held_out    = next_out;
          o.drive     = word_t'(next_out);
          o.increment = word_t'(last_inc);
        end
        predicted_moves.push_back(o);
      end
    endcase
  endfunction

  function automatic word_t pick_word(int unsigned span, int unsigned wild);
    int unsigned r;
    r = $urandom_range(0, wild - 1);
    if (r == 0) return W_MAX;
    if (r == 1) return W_MIN;
    if (r == 2) return word_t'($urandom);
    return word_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic ctl_word_t make_word(cmd_e c, int idx, word_t v, word_t sp, word_t ms);
    ctl_word_t w;
    w.command     = c;
    w.entry_index = IDX_W'(idx);
    w.entry_value = v;
    w.setpoint    = sp;
    w.measured    = ms;
    return w;
  endfunction

  function automatic void post(ctl_word_t w);
    cmd_words_q.push_back(w);
    words_posted++;
  endfunction

  // mostly tracking runs around a held target, with loads and clears mixed in
  function automatic void post_random(int count);
    ctl_word_t w;
    word_t     target;
    int        r;
    int        k;
    target = pick_word(8 * ONE, 20);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) target = pick_word(8 * ONE, 10);
      r             = $urandom_range(0, 99);
      w.entry_index = IDX_W'($urandom_range(0, GAIN_MAX - 1));
      w.entry_value = pick_word(ONE, 40);
      if ($urandom_range(0, 9) != 0) begin
        w.setpoint = target;
        w.measured = target + word_t'(int'($urandom_range(0, ONE)) - ONE / 2);
      end else begin
        w.setpoint = pick_word(8 * ONE, 8);
        w.measured = pick_word(8 * ONE, 8);
      end
      if (r < 70) begin
        w.command = CMD_STEP;
      end else if (r < 82) begin
        w.command = CMD_LOAD_RESP;
      end else if (r < 94) begin
        w.command     = CMD_LOAD_GAIN;
        w.entry_value = pick_word(4096, 40);
      end else begin
        w.command = CMD_CLEAR;
      end
      post(w);
    end
  endfunction

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RESP_LEN:     resp_len_q = value[RESP_LEN_W-1:0];
      REG_CTRL_HORIZON: horizon_q  = value[HORIZON_W-1:0];
      REG_CLAMP_ENABLE: clamp_en_q = value[0];
      REG_CLAMP_MIN:    clamp_lo_q = value;
      REG_CLAMP_MAX:    clamp_hi_q = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (words_taken != words_posted || predicted_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int rl, int hz, bit ce, word_t lo, word_t hi, int count,
                           bit squeeze);
    cfg_write(REG_RESP_LEN, 32'(rl));
    cfg_write(REG_CTRL_HORIZON, 32'(hz));
    cfg_write(REG_CLAMP_ENABLE, {31'd0, ce});
    cfg_write(REG_CLAMP_MIN, lo);
    cfg_write(REG_CLAMP_MAX, hi);
    post_random(count);
    if (squeeze) hold_requests <= hold_requests + 1;
    wait_idle();
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        advance_controller(on_bus);
        words_taken++;
        if ($urandom_range(0, 39) == 0) in_idle_on = !in_idle_on;
        in_gap = in_idle_on ? $urandom_range(0, 11) : 0;
      end
      if (!req_if.valid || req_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          req_if.valid <= 1'b0;
        end else if (cmd_words_q.size() != 0) begin
          on_bus = cmd_words_q.pop_front();
          req_if.command     <= on_bus.command;
          req_if.entry_index <= on_bus.entry_index;
          req_if.entry_value <= on_bus.entry_value;
          req_if.setpoint    <= on_bus.setpoint;
          req_if.measured    <= on_bus.measured;
          req_if.valid       <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (predicted_moves.size() == 0) begin
          $error("unexpected control word: drive %0d increment %0d clamped %0b",
                 rsp_if.drive, rsp_if.increment, rsp_if.clamped);
          fail_count++;
        end else begin
          want = predicted_moves.pop_front();
          if (rsp_if.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, rsp_if.drive);
            fail_count++;
          end
          if (rsp_if.increment !== want.increment) begin
            $error("increment: expected %0d, got %0d", want.increment, rsp_if.increment);
            fail_count++;
          end
          if (rsp_if.clamped !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, rsp_if.clamped);
            fail_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
        out_stall = out_idle_on ? $urandom_range(0, 11) : 0;
      end
      if (hold_taken != hold_requests) begin
        hold_taken = hold_requests;
        out_stall  = LONG_HOLD;
      end
      if (out_stall > 0) begin
        out_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int i;
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.command     = CMD_STEP;
    req_if.entry_index = '0;
    req_if.entry_value = '0;
    req_if.setpoint    = '0;
    req_if.measured    = '0;
    rsp_if.ready       = 1'b0;

    resp_len_q = RESP_LEN_RST;
    horizon_q  = CTRL_HORIZON_RST;
    clamp_en_q = 1'b0;
    clamp_lo_q = '0;
    clamp_hi_q = '0;
    foreach (resp_tab[j]) resp_tab[j] = '0;
    foreach (gain_tab[j]) gain_tab[j] = '0;
    wipe_loop_state();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // fill both tables before any step reads them
    for (i = 0; i < RESP_MAX; i++) begin
      post(make_word(CMD_LOAD_RESP, i, word_t'((i + 1) * 1000 + $urandom_range(0, 500)),
                     pick_word(ONE, 8), pick_word(ONE, 8)));
    end
    for (i = 0; i < GAIN_MAX; i++) begin
      post(make_word(CMD_LOAD_GAIN, i, word_t'(int'($urandom_range(0, 8192)) - 4096),
                     pick_word(ONE, 8), pick_word(ONE, 8)));
    end

    // directed words at the reset settings
    post(make_word(CMD_STEP, 0, 0, 0, 0));
    post(make_word(CMD_STEP, 0, 0, ONE, 0));
    post(make_word(CMD_STEP, 0, 0, W_MAX, W_MIN));
    post(make_word(CMD_STEP, 0, 0, W_MIN, W_MAX));
    post(make_word(CMD_CLEAR, 0, 0, 0, 0));
    post(make_word(CMD_STEP, 0, 0, 2 * ONE, ONE));
    post(make_word(CMD_STEP, 0, 0, 3 * ONE, ONE));
    post(make_word(CMD_LOAD_RESP, 64, W_MAX, 0, 0));
    post(make_word(CMD_LOAD_RESP, 79, W_MIN, 0, 0));
    post(make_word(CMD_STEP, 0, 0, 3 * ONE, 2 * ONE));
    post(make_word(CMD_LOAD_GAIN, 79, W_MIN, 0, 0));
    post(make_word(CMD_LOAD_GAIN, 0, W_MAX, 0, 0));
    post(make_word(CMD_LOAD_RESP, 0, W_MAX, 0, 0));
    post(make_word(CMD_LOAD_RESP, 63, W_MIN, 0, 0));
    post(make_word(CMD_STEP, 0, 0, ONE, -ONE));
    post(make_word(CMD_STEP, 0, 0, -ONE, ONE));
    post(make_word(CMD_LOAD_RESP, 0, 1000, 0, 0));
    post(make_word(CMD_LOAD_RESP, 63, ONE, 0, 0));
    post(make_word(CMD_LOAD_GAIN, 0, 2048, 0, 0));
    post(make_word(CMD_LOAD_GAIN, 79, -2048, 0, 0));
    post(make_word(CMD_STEP, 127, -1, ONE, ONE / 2));
    post(make_word(CMD_CLEAR, 127, -1, -1, -1));
    post(make_word(CMD_CLEAR, 0, 0, 0, 0));
    post(make_word(CMD_STEP, 0, 0, ONE, 0));
    post(make_word(CMD_STEP, 0, 0, ONE, 0));
    post_random(60);
    wait_idle();

    run_phase(2, 16, 1'b1, -2 * ONE, 2 * ONE, 130, 1'b0);
    run_phase(17, 5, 1'b1, -ONE / 2, ONE / 2, 130, 1'b1);
    run_phase(0, 0, 1'b0, W_MIN, W_MAX, 120, 1'b0);
    run_phase(127, 31, 1'b1, W_MIN, W_MAX, 100, 1'b0);
    run_phase(64, 16, 1'b1, ONE, -ONE, 100, 1'b0);
    run_phase(1, 17, 1'b1, W_MAX, W_MAX, 80, 1'b0);
    run_phase(40, 8, 1'b1, W_MIN, W_MIN, 80, 1'b0);
    for (i = 0; i < 4; i++) begin
      run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 20),
                $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                pick_word(4 * ONE, 8), pick_word(4 * ONE, 8), 80, 1'b0);
    end

    if (fail_count == 0 && predicted_moves.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
